@@ rtl/gchg_pkg.sv @@
package gchg_pkg;

  // number of denomination slots and field widths of the channels
  localparam int unsigned SLOTS       = 9;
  localparam int unsigned SLOT_BITS   = 4;
  localparam int unsigned STOCK_BITS  = 16;
  localparam int unsigned AMT_BITS    = 20;
  localparam int unsigned STATUS_BITS = 2;
  localparam int unsigned DENOM_BITS  = 9;
  localparam int unsigned POW5_BITS   = 7;

  // defaults of the top level parameters
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned AMOUNT_BITS_DEF = 20;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_CHANGE = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FAIL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_PIECE = 2'd2;

  // face value of each slot
  function automatic logic [DENOM_BITS-1:0] denom_value(input logic [SLOT_BITS-1:0] slot);
    logic [DENOM_BITS-1:0] val;
    case (slot)
      4'd0:    val = 9'd1;
      4'd1:    val = 9'd2;
      4'd2:    val = 9'd5;
      4'd3:    val = 9'd10;
      4'd4:    val = 9'd20;
      4'd5:    val = 9'd50;
      4'd6:    val = 9'd100;
      4'd7:    val = 9'd200;
      4'd8:    val = 9'd500;
      default: val = 9'd1;
    endcase
    return val;
  endfunction

  // face value = 2^shift * 5^exp, power of two part
  function automatic logic [1:0] slot_shift(input logic [SLOT_BITS-1:0] slot);
    logic [1:0] sh;
    case (slot)
      4'd1:    sh = 2'd1;
      4'd3:    sh = 2'd1;
      4'd4:    sh = 2'd2;
      4'd5:    sh = 2'd1;
      4'd6:    sh = 2'd2;
      4'd7:    sh = 2'd3;
      4'd8:    sh = 2'd2;
      default: sh = 2'd0;
    endcase
    return sh;
  endfunction

  // power of five part, as exponent
  function automatic logic [1:0] slot_pow5_exp(input logic [SLOT_BITS-1:0] slot);
    logic [1:0] ex;
    case (slot)
      4'd2:    ex = 2'd1;
      4'd3:    ex = 2'd1;
      4'd4:    ex = 2'd1;
      4'd5:    ex = 2'd2;
      4'd6:    ex = 2'd2;
      4'd7:    ex = 2'd2;
      4'd8:    ex = 2'd3;
      default: ex = 2'd0;
    endcase
    return ex;
  endfunction

  function automatic logic [POW5_BITS-1:0] pow5_value(input logic [1:0] ex);
    logic [POW5_BITS-1:0] val;
    case (ex)
      2'd1:    val = 7'd5;
      2'd2:    val = 7'd25;
      2'd3:    val = 7'd125;
      default: val = 7'd1;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/gchg_if.sv @@
// request channel
interface gchg_req_if;
  import gchg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [SLOT_BITS-1:0]  denom_index;
  logic [STOCK_BITS-1:0] stock_value;
  logic [AMT_BITS-1:0]   amount;

  modport source (output valid, req_type, denom_index, stock_value, amount, input ready);
  modport sink (input valid, req_type, denom_index, stock_value, amount, output ready);
endinterface

// result channel
interface gchg_res_if;
  import gchg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SLOT_BITS-1:0]   out_index;
  logic [STOCK_BITS-1:0]  piece_count;
  logic [STOCK_BITS-1:0]  stock_left;
  logic [STATUS_BITS-1:0] status;
  logic                   last;

  modport source (output valid, out_index, piece_count, stock_left, status, last, input ready);
  modport sink (input valid, out_index, piece_count, stock_left, status, last, output ready);
endinterface

@@ rtl/gchg_ram.sv @@
module gchg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 9,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/greedy_change_dispenser.sv @@
// channel | port  | direction | payload
// request | req_i | in        | req_type, denom_index, stock_value, amount
// result  | res_o | out       | out_index, piece_count, stock_left, status, last
//
// a load item goes straight to the close step, which registers its closing item
// a paid change item plans each slot (read stock, reciprocal multiply, correct and clamp,
// subtract), then a check, then pays each slot (read, update), then the close
// a change item that cannot be paid closes right after the check, with no payout
// reset clears the stock through per-slot valid bits, no clearing pass
// a stalled result channel holds the sequencer in the payout pass or the close step
module greedy_change_dispenser #(
  parameter int unsigned COUNT_BITS  = gchg_pkg::COUNT_BITS_DEF,
  parameter int unsigned AMOUNT_BITS = gchg_pkg::AMOUNT_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  gchg_req_if.sink   req_i,
  gchg_res_if.source res_o
);
  import gchg_pkg::*;

  localparam int unsigned CMP_BITS = (AMOUNT_BITS > COUNT_BITS) ? AMOUNT_BITS : COUNT_BITS;
  localparam logic [63:0] AMT_ONE = 64'd1 << AMOUNT_BITS;
  // floor(2^AMOUNT_BITS / 5^k): quotient estimate is low by at most one
  localparam logic [AMOUNT_BITS-1:0] RECIP_5   = AMOUNT_BITS'(AMT_ONE / 64'd5);
  localparam logic [AMOUNT_BITS-1:0] RECIP_25  = AMOUNT_BITS'(AMT_ONE / 64'd25);
  localparam logic [AMOUNT_BITS-1:0] RECIP_125 = AMOUNT_BITS'(AMT_ONE / 64'd125);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_TAKE  = 4'd3;
  localparam logic [3:0] S_SUB   = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_RD2   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_CLOSE = 4'd8;

  localparam logic [SLOT_BITS-1:0] TOP_SLOT = SLOT_BITS'(SLOTS - 1);

  logic [3:0]                 state_q, state_d;
  logic [SLOT_BITS-1:0]       slot_q, slot_d;
  logic [AMOUNT_BITS-1:0]     rem_q, rem_d;
  logic [AMOUNT_BITS-1:0]     x_q;
  logic [2*AMOUNT_BITS-1:0]   prod_q;
  logic [AMOUNT_BITS-1:0]     q0_q, qd_q;
  logic [COUNT_BITS-1:0]      take_q, take_c;
  logic [SLOT_BITS-1:0]       cl_idx_q, cl_idx_d;
  logic [STOCK_BITS-1:0]      cl_left_q, cl_left_d;
  logic [STATUS_BITS-1:0]     cl_status_q, cl_status_d;
  logic                       out_vld_q, out_vld_d;
  logic [SLOT_BITS-1:0]       out_idx_q, out_idx_d;
  logic [STOCK_BITS-1:0]      out_cnt_q, out_cnt_d;
  logic [STOCK_BITS-1:0]      out_left_q, out_left_d;
  logic [STATUS_BITS-1:0]     out_status_q, out_status_d;
  logic                       out_last_q, out_last_d;
  logic [SLOTS-1:0]           stk_vld_q;
  logic                       stk_rd_vld_q;

  logic                       req_acc, out_free, rd_en;
  logic                       stk_we, plan_we;
  logic [SLOT_BITS-1:0]       stk_waddr;
  logic [COUNT_BITS-1:0]      stk_wdata, stk_rdata, stock_rd, plan_rd, stock_new;
  logic [AMOUNT_BITS-1:0]     recip, quot, paid, x_c;
  logic [POW5_BITS-1:0]       pow5;
  logic [1:0]                 p5_exp;
  logic [AMOUNT_BITS+31:0]    amt_wide;
  logic [COUNT_BITS+31:0]     cnt_wide;
  logic [AMOUNT_BITS-1:0]     amt_in;
  logic [COUNT_BITS-1:0]      cnt_in;
  logic [COUNT_BITS+15:0]     new_wide, plan_wide, cnt16_wide;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || res_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // fit request fields to the configured widths
  assign amt_wide = {32'd0, req_i.amount};
  assign amt_in   = amt_wide[AMOUNT_BITS-1:0];
  assign cnt_wide = {32'd0, req_i.stock_value};
  assign cnt_in   = cnt_wide[COUNT_BITS-1:0];

  // stock and plan memories
  gchg_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_stock_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (rd_en),
    .raddr_i (slot_q),
    .rdata_o (stk_rdata)
  );

  gchg_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_plan_ram (
    .clk_i   (clk_i),
    .we_i    (plan_we),
    .waddr_i (slot_q),
    .wdata_i (take_c),
    .re_i    (rd_en),
    .raddr_i (slot_q),
    .rdata_o (plan_rd)
  );

  // a stock entry never loaded reads as zero
  assign stock_rd = stk_rd_vld_q ? stk_rdata : '0;
  // each slot is read, then written back, before the next slot is touched
  assign stock_new = stock_rd - plan_rd;
  assign rd_en   = (state_q == S_DIV) || (state_q == S_RD2);
  assign plan_we = (state_q == S_TAKE);

  // divider constants of the current slot
  assign p5_exp = slot_pow5_exp(slot_q);
  assign pow5   = pow5_value(p5_exp);
  assign x_c    = rem_q >> slot_shift(slot_q);

  always_comb begin
    case (p5_exp)
      2'd1:    recip = RECIP_5;
      2'd2:    recip = RECIP_25;
      2'd3:    recip = RECIP_125;
      default: recip = '0;
    endcase
  end

  // corrected quotient, clamped by the stock
  assign quot = q0_q + AMOUNT_BITS'((x_q - qd_q) >= AMOUNT_BITS'(pow5));
  always_comb begin
    if (CMP_BITS'(quot) < CMP_BITS'(stock_rd)) begin
      take_c = COUNT_BITS'(quot);
    end else begin
      take_c = stock_rd;
    end
  end

  assign paid = AMOUNT_BITS'(take_q) * AMOUNT_BITS'(denom_value(slot_q));

  assign new_wide   = {16'd0, stock_new};
  assign plan_wide  = {16'd0, plan_rd};
  assign cnt16_wide = {16'd0, cnt_in};

  // sequencer
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    rem_d        = rem_q;
    cl_idx_d     = cl_idx_q;
    cl_left_d    = cl_left_q;
    cl_status_d  = cl_status_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    out_idx_d    = out_idx_q;
    out_cnt_d    = out_cnt_q;
    out_left_d   = out_left_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    stk_we       = 1'b0;
    stk_waddr    = slot_q;
    stk_wdata    = stock_new;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          if (req_i.req_type == REQ_LOAD) begin
            cl_idx_d = req_i.denom_index;
            if (req_i.denom_index < SLOT_BITS'(SLOTS)) begin
              stk_we      = 1'b1;
              stk_waddr   = req_i.denom_index;
              stk_wdata   = cnt_in;
              cl_left_d   = cnt16_wide[15:0];
              cl_status_d = ST_OK;
            end else begin
              cl_left_d   = '0;
              cl_status_d = ST_FAIL;
            end
            state_d = S_CLOSE;
          end else begin
            rem_d   = amt_in;
            slot_d  = TOP_SLOT;
            state_d = S_DIV;
          end
        end
      end
      S_DIV:  state_d = S_MUL;
      S_MUL:  state_d = S_TAKE;
      S_TAKE: state_d = S_SUB;
      S_SUB: begin
        rem_d = rem_q - paid;
        if (slot_q == '0) begin
          state_d = S_CHECK;
        end else begin
          slot_d  = slot_q - SLOT_BITS'(1);
          state_d = S_DIV;
        end
      end
      S_CHECK: begin
        cl_idx_d  = '0;
        cl_left_d = '0;
        if (rem_q != '0) begin
          cl_status_d = ST_FAIL;
          state_d     = S_CLOSE;
        end else begin
          cl_status_d = ST_OK;
          slot_d      = TOP_SLOT;
          state_d     = S_RD2;
        end
      end
      S_RD2: state_d = S_UPD;
      S_UPD: begin
        if (plan_rd == '0 || out_free) begin
          if (plan_rd != '0) begin
            stk_we       = 1'b1;
            out_vld_d    = 1'b1;
            out_idx_d    = slot_q;
            out_cnt_d    = plan_wide[15:0];
            out_left_d   = new_wide[15:0];
            out_status_d = ST_PIECE;
            out_last_d   = 1'b0;
          end
          if (slot_q == '0) begin
            state_d = S_CLOSE;
          end else begin
            slot_d  = slot_q - SLOT_BITS'(1);
            state_d = S_RD2;
          end
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_idx_d    = cl_idx_q;
          out_cnt_d    = '0;
          out_left_d   = cl_left_q;
          out_status_d = cl_status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_q       <= '0;
      rem_q        <= '0;
      out_vld_q    <= 1'b0;
      stk_vld_q    <= '0;
      stk_rd_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
      if (stk_we) begin
        stk_vld_q[stk_waddr] <= 1'b1;
      end
      if (rd_en) begin
        stk_rd_vld_q <= stk_vld_q[slot_q];
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV) begin
      x_q    <= x_c;
      prod_q <= x_c * recip;
    end
    if (state_q == S_MUL) begin
      if (p5_exp == 2'd0) begin
        q0_q <= x_q;
        qd_q <= x_q;
      end else begin
        q0_q <= prod_q[2*AMOUNT_BITS-1:AMOUNT_BITS];
        qd_q <= prod_q[2*AMOUNT_BITS-1:AMOUNT_BITS] * AMOUNT_BITS'(pow5);
      end
    end
    if (state_q == S_TAKE) begin
      take_q <= take_c;
    end
    cl_idx_q     <= cl_idx_d;
    cl_left_q    <= cl_left_d;
    cl_status_q  <= cl_status_d;
    out_idx_q    <= out_idx_d;
    out_cnt_q    <= out_cnt_d;
    out_left_q   <= out_left_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.out_index   = out_idx_q;
  assign res_o.piece_count = out_cnt_q;
  assign res_o.stock_left  = out_left_q;
  assign res_o.status      = out_status_q;
  assign res_o.last        = out_last_q;

`ifndef SYNTHESIS
  // reciprocal estimate is never off by more than one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |-> ((x_q - qd_q) < (AMOUNT_BITS'(pow5) << 1)))
    else $error("quotient estimate out of range");

  // planned take never exceeds the stock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |-> (CMP_BITS'(take_q) <= CMP_BITS'(stock_rd)))
    else $error("take above stock");

  // payout never underflows a stock entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (plan_rd <= stock_rd))
    else $error("stock underflow in payout");

  // a leftover remainder closes the run with a failure and no payout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && rem_q != '0) |=> (state_q == S_CLOSE && cl_status_q == ST_FAIL))
    else $error("impossible change not reported");
`endif

endmodule

@@ dv/change_payout_checker.sv @@
module change_payout_checker #(
  parameter int unsigned COUNT_BITS  = gchg_pkg::COUNT_BITS_DEF,
  parameter int unsigned AMOUNT_BITS = gchg_pkg::AMOUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gchg_req_if         req_i,
  gchg_res_if         res_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gchg_pkg::*;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   idx;
    logic [STOCK_BITS-1:0]  pieces;
    logic [STOCK_BITS-1:0]  left;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } payout_t;

  localparam longint unsigned COUNT_MASK  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned AMOUNT_MASK = (64'd1 << AMOUNT_BITS) - 64'd1;
  localparam longint unsigned FACE [SLOTS] = '{1, 2, 5, 10, 20, 50, 100, 200, 500};

  longint unsigned coin_stock [SLOTS];
  payout_t         payout_q [$];
  int unsigned     mismatches;

  function automatic payout_t payout_entry(input longint unsigned idx, input longint unsigned pieces,
                                           input longint unsigned left,
                                           input logic [STATUS_BITS-1:0] st, input logic fin);
    payout_t p;
    p.idx    = SLOT_BITS'(idx);
    p.pieces = STOCK_BITS'(pieces);
    p.left   = STOCK_BITS'(left);
    p.status = st;
    p.last   = fin;
    return p;
  endfunction

  // greedy pass from the largest face value down, stock touched only on success
  task automatic plan_payout(input logic kind, input logic [SLOT_BITS-1:0] slot,
                             input logic [STOCK_BITS-1:0] load_val,
                             input logic [AMT_BITS-1:0] amt);
    longint unsigned rest;
    longint unsigned fit;
    longint unsigned plan [SLOTS];
    int              s;
    if (kind == REQ_LOAD) begin
      if (slot < SLOTS) begin
        coin_stock[slot] = 64'(load_val) & COUNT_MASK;
        payout_q.push_back(payout_entry(64'(slot), 0, coin_stock[slot], ST_OK, 1'b1));
      end else begin
        payout_q.push_back(payout_entry(64'(slot), 0, 0, ST_FAIL, 1'b1));
      end
      return;
    end
    rest = 64'(amt) & AMOUNT_MASK;
    for (s = SLOTS - 1; s >= 0; s--) begin
      fit     = rest / FACE[s];
      plan[s] = (fit < coin_stock[s]) ? fit : coin_stock[s];
      rest    = rest - plan[s] * FACE[s];
    end
    if (rest != 0) begin
      payout_q.push_back(payout_entry(0, 0, 0, ST_FAIL, 1'b1));
      return;
    end
    for (s = SLOTS - 1; s >= 0; s--) begin
      if (plan[s] != 0) begin
        coin_stock[s] = coin_stock[s] - plan[s];
        payout_q.push_back(payout_entry(64'(s), plan[s], coin_stock[s], ST_PIECE, 1'b0));
      end
    end
    payout_q.push_back(payout_entry(0, 0, 0, ST_OK, 1'b1));
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // results are checked before the new request is planned
  always @(posedge clk_i or negedge rst_ni) begin
    payout_t want;
    if (!rst_ni) begin
      foreach (coin_stock[s]) coin_stock[s] = 0;
      payout_q.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (payout_q.size() == 0) begin
          mismatches++;
          $error("result item with nothing expected: out_index %0d status %0d",
                 res_i.out_index, res_i.status);
        end else begin
          want = payout_q.pop_front();
          check_field("out_index", 64'(want.idx), 64'(res_i.out_index));
          check_field("piece_count", 64'(want.pieces), 64'(res_i.piece_count));
          check_field("stock_left", 64'(want.left), 64'(res_i.stock_left));
          check_field("status", 64'(want.status), 64'(res_i.status));
          check_field("last", 64'(want.last), 64'(res_i.last));
        end
      end
      if (req_i.valid && req_i.ready) begin
        plan_payout(req_i.req_type, req_i.denom_index, req_i.stock_value, req_i.amount);
      end
      pending_o <= payout_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

@@ dv/tb_greedy_change_dispenser.sv @@
module tb_greedy_change_dispenser;
  timeunit 1ns;
  timeprecision 1ps;

  import gchg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 52;

  typedef struct {
    logic                  kind;
    logic [SLOT_BITS-1:0]  slot;
    logic [STOCK_BITS-1:0] load_val;
    logic [AMT_BITS-1:0]   amt;
  } coin_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_req;
  logic        hold_done;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_cnt = 0;

  gchg_req_if req_ch ();
  gchg_res_if res_ch ();

  greedy_change_dispenser i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  change_payout_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_ch),
    .res_i     (res_ch),
    .pending_o (pending),
    .errors_o  (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // mostly change items with small amounts, some loads, a few wide values
  function automatic coin_req_t random_request();
    coin_req_t   rq;
    int unsigned pick;
    pick    = $urandom_range(99);
    rq.kind = (pick < 30) ? REQ_LOAD : REQ_CHANGE;
    if ($urandom_range(9) == 0) rq.slot = SLOT_BITS'($urandom_range(15, 9));
    else rq.slot = SLOT_BITS'($urandom_range(8));
    pick = $urandom_range(99);
    if (pick < 50) rq.load_val = STOCK_BITS'($urandom_range(40));
    else if (pick < 85) rq.load_val = STOCK_BITS'($urandom_range(2000));
    else rq.load_val = STOCK_BITS'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) rq.amt = '0;
    else if (pick < 60) rq.amt = AMT_BITS'($urandom_range(999, 1));
    else if (pick < 85) rq.amt = AMT_BITS'($urandom_range(50000, 1000));
    else rq.amt = AMT_BITS'($urandom);
    return rq;
  endfunction

  // valid stays high into the next item unless an idle gap is drawn
  task automatic offer_request(input coin_req_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rq.kind;
    req_ch.denom_index <= rq.slot;
    req_ch.stock_value <= rq.load_val;
    req_ch.amount      <= rq.amt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic load_slot(input int unsigned slot, input int unsigned count);
    coin_req_t rq;
    rq          = random_request();
    rq.kind     = REQ_LOAD;
    rq.slot     = SLOT_BITS'(slot);
    rq.load_val = STOCK_BITS'(count);
    offer_request(rq);
  endtask

  task automatic pay_amount(input int unsigned amount);
    coin_req_t rq;
    rq      = random_request();
    rq.kind = REQ_CHANGE;
    rq.amt  = AMT_BITS'(amount);
    offer_request(rq);
  endtask

  // sender pauses until every expected result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_LOAD;
    req_ch.denom_index = '0;
    req_ch.stock_value = '0;
    req_ch.amount      = '0;
    hold_req           = 1'b0;
    send_idle_pct      = 33;
    recv_idle_pct      = 71;
    rst_n              = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero amount and empty stock
    pay_amount(0);
    pay_amount(1);
    // loads to slots past the last denomination are rejected
    load_slot(15, 16'hFFFF);
    load_slot(9, 1);
    // full-scale piece count from the unit slot
    load_slot(0, 65535);
    pay_amount(65535);
    // greedy trap: 6 from one five and twos fails, stock kept
    load_slot(2, 1);
    load_slot(1, 3);
    pay_amount(6);
    pay_amount(4);
    // every denomination used in one payout
    load_slot(8, 2);
    load_slot(7, 1);
    load_slot(6, 3);
    load_slot(5, 2);
    load_slot(4, 1);
    load_slot(3, 4);
    load_slot(0, 10);
    pay_amount(888);
    // largest amounts
    pay_amount(20'hFFFFF);
    load_slot(8, 65535);
    pay_amount(1048500);
    pay_amount(20'hFFFFF);
    load_slot(3, 0);
    drain_results();

    // random phases with different idle mixes, long result hold-off in the last
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20) hold_req <= 1'b1;
        offer_request(random_request());
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
